// ===== rtl/core/rfpa_pkg.sv =====
package rfpa_pkg;

    // Quotient bits resolved per divider cycle
    localparam int CHUNK_BITS = 8;
    localparam int DIGIT_W    = 4;
    localparam int RADIX_W    = 5;
    localparam int FRAC_W     = 5;
    localparam int CHAR_W     = 7;

    // Register index, taken from paddr[2]
    localparam logic REG_RADIX = 1'b0;
    localparam logic REG_FRAC  = 1'b1;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_A     = 7'h41;
    localparam logic [CHAR_W-1:0] ASCII_POINT = 7'h2E;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;
    localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 4'd10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_WAIT,
        S_DIGIT,
        S_POINT
    } t_state;

    typedef enum logic [1:0] {
        CH_SIGN,
        CH_DIGIT,
        CH_POINT
    } t_char_sel;

    typedef struct packed {
        logic      load_in;
        logic      div_step;
        logic      emit_en;
        logic      emit_last;
        t_char_sel emit_sel;
        logic      ptr_dec;
    } t_cmd;

    typedef struct packed {
        logic neg;
        logic div_last;
        logic quo_zero;
        logic in_frac;
        logic out_free;
        logic ptr_at_f;
        logic ptr_zero;
        logic f_zero;
    } t_status;

    function automatic logic [CHAR_W-1:0] ascii_of_digit(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d < DECIMAL_LIMIT) begin
            ch = ASCII_ZERO + CHAR_W'(d);
        end else begin
            ch = ASCII_A + CHAR_W'(d - DECIMAL_LIMIT);
        end
        return ch;
    endfunction

endpackage

// ===== rtl/core/rfpa_ram.sv =====
module rfpa_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 63
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/rfpa_ctrl.sv =====
module rfpa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rfpa_pkg::t_status i_status,
    output rfpa_pkg::t_cmd    o_cmd
);
    import rfpa_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        cmd.load_in   = 1'b0;
        cmd.div_step  = 1'b0;
        cmd.emit_en   = 1'b0;
        cmd.emit_last = 1'b0;
        cmd.emit_sel  = CH_DIGIT;
        cmd.ptr_dec   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                // stop once the fraction is done and the quotient ran out
                if (i_status.div_last && !i_status.in_frac && i_status.quo_zero) begin
                    n_state = i_status.neg ? S_SIGN : S_WAIT;
                end
            end
            S_SIGN: begin
                if (i_status.out_free) begin
                    cmd.emit_en  = 1'b1;
                    cmd.emit_sel = CH_SIGN;
                    n_state      = S_WAIT;
                end
            end
            S_WAIT: begin
                // let the digit read settle
                n_state = S_DIGIT;
            end
            S_DIGIT: begin
                if (i_status.out_free) begin
                    cmd.emit_en  = 1'b1;
                    cmd.emit_sel = CH_DIGIT;
                    if (i_status.ptr_at_f && !i_status.f_zero) begin
                        n_state = S_POINT;
                    end else if (i_status.ptr_zero) begin
                        cmd.emit_last = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        cmd.ptr_dec = 1'b1;
                        n_state     = S_WAIT;
                    end
                end
            end
            S_POINT: begin
                if (i_status.out_free) begin
                    cmd.emit_en  = 1'b1;
                    cmd.emit_sel = CH_POINT;
                    cmd.ptr_dec  = 1'b1;
                    n_state      = S_WAIT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== rtl/core/rfpa_dp.sv =====
module rfpa_dp #(
    parameter int VALUE_WIDTH     = 32,
    parameter int MAX_FRAC_DIGITS = 31
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rfpa_pkg::t_cmd                 i_cmd,
    output rfpa_pkg::t_status              o_status,
    input  logic signed [VALUE_WIDTH-1:0]  i_scaled_value,
    input  logic [rfpa_pkg::RADIX_W-1:0]   i_radix,
    input  logic [rfpa_pkg::FRAC_W-1:0]    i_frac_digits,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [rfpa_pkg::CHAR_W-1:0]    o_text_char,
    output logic                           o_last_char
);
    import rfpa_pkg::*;

    localparam int DIV_STEPS   = (VALUE_WIDTH + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int MW          = DIV_STEPS * CHUNK_BITS;
    localparam int STEP_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int STORE_DEPTH = MAX_FRAC_DIGITS + VALUE_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int CMP_W       = CNT_W + FRAC_W;

    logic                   r_neg;
    logic [MW-1:0]          r_mag;
    logic [DIGIT_W-1:0]     r_rem;
    logic [STEP_W-1:0]      r_step;
    logic [RADIX_W-1:0]     r_radix;
    logic [CNT_W-1:0]       r_frac;
    logic [CNT_W-1:0]       r_cnt;
    logic [ADDR_W-1:0]      r_ptr;
    logic                   r_out_valid;
    logic [CHAR_W-1:0]      r_text_char;
    logic                   r_last_char;

    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] mag_in;
    logic [RADIX_W-1:0]     radix_eff;
    logic [CMP_W-1:0]       frac_wide;
    logic [CMP_W-1:0]       frac_max;
    logic [CMP_W-1:0]       frac_eff;
    logic [DIGIT_W-1:0]     n_rem;
    logic [CHUNK_BITS-1:0]  q_chunk;
    logic [MW-1:0]          n_mag;
    logic                   div_last;
    logic                   dig_we;
    logic [DIGIT_W-1:0]     rd_digit;
    logic                   out_free;
    logic [CHAR_W-1:0]      n_char;

    // Input magnitude and clamped settings
    always_comb begin
        raw       = i_scaled_value;
        mag_in    = raw[VALUE_WIDTH-1] ? ((~raw) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;
        radix_eff = i_radix;
        if (i_radix < RADIX_MIN) begin
            radix_eff = RADIX_MIN;
        end else if (i_radix > RADIX_MAX) begin
            radix_eff = RADIX_MAX;
        end
        frac_wide = CMP_W'(i_frac_digits);
        frac_max  = CMP_W'(MAX_FRAC_DIGITS);
        frac_eff  = (frac_wide > frac_max) ? frac_max : frac_wide;
    end

    // One chunk of restoring division by the radix
    always_comb begin
        logic [DIGIT_W:0] trial;
        logic [DIGIT_W-1:0] rem;
        rem     = r_rem;
        q_chunk = '0;
        for (int k = 0; k < CHUNK_BITS; k++) begin
            trial = {rem, r_mag[MW-1-k]};
            if (trial >= r_radix) begin
                trial                   = trial - r_radix;
                q_chunk[CHUNK_BITS-1-k] = 1'b1;
            end
            rem = trial[DIGIT_W-1:0];
        end
        n_rem = rem;
        n_mag = (r_mag << CHUNK_BITS) | MW'(q_chunk);
    end

    assign div_last = (r_step == STEP_W'(DIV_STEPS - 1));
    assign dig_we   = i_cmd.div_step && div_last;

    // Divider and digit bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_neg   <= raw[VALUE_WIDTH-1];
            r_mag   <= MW'(mag_in);
            r_rem   <= '0;
            r_step  <= '0;
            r_radix <= radix_eff;
            r_frac  <= frac_eff[CNT_W-1:0];
            r_cnt   <= '0;
        end else if (i_cmd.div_step) begin
            r_mag <= n_mag;
            if (div_last) begin
                r_rem  <= '0;
                r_step <= '0;
                r_cnt  <= r_cnt + 1'b1;
                r_ptr  <= r_cnt[ADDR_W-1:0];
            end else begin
                r_rem  <= n_rem;
                r_step <= r_step + 1'b1;
            end
        end else if (i_cmd.ptr_dec) begin
            r_ptr <= r_ptr - 1'b1;
        end
    end

    rfpa_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (STORE_DEPTH)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (dig_we),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (n_rem),
        .i_raddr (r_ptr),
        .o_rdata (rd_digit)
    );

    // Character select
    always_comb begin
        unique case (i_cmd.emit_sel)
            CH_SIGN:  n_char = ASCII_MINUS;
            CH_POINT: n_char = ASCII_POINT;
            CH_DIGIT: n_char = ascii_of_digit(rd_digit);
            default:  n_char = ascii_of_digit(rd_digit);
        endcase
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // Output register: hold while stalled, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_en) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_en) begin
            r_text_char <= n_char;
            r_last_char <= i_cmd.emit_last;
        end
    end

    assign o_status.neg      = r_neg;
    assign o_status.div_last = div_last;
    assign o_status.quo_zero = (n_mag == '0);
    assign o_status.in_frac  = (r_cnt < r_frac);
    assign o_status.out_free = out_free;
    assign o_status.ptr_at_f = (CNT_W'(r_ptr) == r_frac);
    assign o_status.ptr_zero = (r_ptr == '0);
    assign o_status.f_zero   = (r_frac == '0);

    assign o_out_valid = r_out_valid;
    assign o_text_char = r_text_char;
    assign o_last_char = r_last_char;

endmodule

// ===== rtl/core/radix_fixed_point_to_ascii.sv =====
// Signed fixed-point to ASCII text converter.
// Input channel: one beat carries i_scaled_value, a two's complement number
// already scaled by radix^frac_digits. o_in_stall is high while a number is
// being converted or printed; the next beat is taken once the last character
// has been loaded into the output register.
// Output channel: one beat per character: '-' for negative values, integer
// digits (at least one), then '.' and frac_digits fractional digits when
// frac_digits is nonzero. o_last_char marks the final character.
// Configuration (APB, write only while idle): radix at 0x0, frac_digits at
// 0x4. Radix is clamped to 2..16 and frac_digits to MAX_FRAC_DIGITS.
// Each digit comes from one pass of the shared 8-bit-per-cycle radix divider,
// least significant digit first, and is stored in the digit memory. Printing
// then reads each digit back through the registered digit memory read, with
// a wait state before each digit, and emits the minus sign and the point from
// their own states.
// Reset clears the control state and sets radix 10, frac_digits 0; no
// clearing pass is needed. A stall on the output holds the current character
// and pauses printing without losing data.
module radix_fixed_point_to_ascii #(
    parameter int VALUE_WIDTH     = 32,
    parameter int MAX_FRAC_DIGITS = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_scaled_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [6:0]                    o_text_char,
    output logic                          o_last_char
);
    import rfpa_pkg::*;

    logic [RADIX_W-1:0] r_radix;
    logic [FRAC_W-1:0]  r_frac_digits;
    logic               cfg_wr;
    t_cmd               cmd;
    t_status            status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix       <= RADIX_RESET;
            r_frac_digits <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_RADIX: r_radix       <= pwdata[RADIX_W-1:0];
                REG_FRAC:  r_frac_digits <= pwdata[FRAC_W-1:0];
                default:   r_radix       <= r_radix;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (paddr[2])
            REG_RADIX: prdata = 32'(r_radix);
            REG_FRAC:  prdata = 32'(r_frac_digits);
            default:   prdata = '0;
        endcase
    end

    rfpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rfpa_dp #(
        .VALUE_WIDTH     (VALUE_WIDTH),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_scaled_value (i_scaled_value),
        .i_radix        (r_radix),
        .i_frac_digits  (r_frac_digits),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_text_char    (o_text_char),
        .o_last_char    (o_last_char)
    );

endmodule

// ===== tb/rfpa_text_checker.sv =====
// Watch the configuration port and both channels of the converter, predict
// the text of every accepted number and compare each output beat with it.
module rfpa_text_checker #(
    parameter int VALUE_W  = 32,
    parameter int MAX_FRAC = 31
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [2:0]                  i_paddr,
    input  logic [31:0]                 i_pwdata,
    input  logic                        i_pready,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [VALUE_W-1:0]          i_scaled_value,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [rfpa_pkg::CHAR_W-1:0] i_text_char,
    input  logic                        i_last_char,
    output int                          o_mismatches,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rfpa_pkg::*;

    // Frac digits plus integer digits never exceed this many
    localparam int DIGIT_SLOTS = 63;
    localparam int REPORT_CAP  = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char_beat;

    t_char_beat         text_queue[$];
    logic [RADIX_W-1:0] radix_q;
    logic [FRAC_W-1:0]  frac_q;
    int                 mismatches = 0;

    assign o_mismatches = mismatches;

    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
        if (d <= 4'd9) begin
            return ASCII_ZERO + CHAR_W'(d);
        end
        return ASCII_A + CHAR_W'(d - 4'd10);
    endfunction

    function automatic void queue_char(input logic [CHAR_W-1:0] ch);
        t_char_beat beat;
        beat.ch    = ch;
        beat.last  = 1'b0;
        text_queue = {text_queue, beat};
    endfunction

    // Expand one number into its expected characters
    function automatic void predict_text(input logic [VALUE_W-1:0] raw);
        logic [DIGIT_W-1:0] digits [DIGIT_SLOTS];
        logic [VALUE_W-1:0] mag;
        logic               neg;
        t_char_beat         tail;
        int                 base;
        int                 nfrac;
        int                 n;
        int                 i;
        neg = raw[VALUE_W-1];
        mag = neg ? (~raw + 1'b1) : raw;
        base = int'(radix_q);
        if (base < int'(RADIX_MIN)) begin
            base = int'(RADIX_MIN);
        end
        if (base > int'(RADIX_MAX)) begin
            base = int'(RADIX_MAX);
        end
        nfrac = int'(frac_q);
        if (nfrac > MAX_FRAC) begin
            nfrac = MAX_FRAC;
        end
        n = 0;
        // Peel fractional digits, least significant first
        for (i = 0; i < nfrac && n < DIGIT_SLOTS; i++) begin
            digits[n] = DIGIT_W'(mag % VALUE_W'(base));
            n++;
            mag = mag / VALUE_W'(base);
        end
        // Peel integer digits, at least one
        do begin
            if (n < DIGIT_SLOTS) begin
                digits[n] = DIGIT_W'(mag % VALUE_W'(base));
                n++;
            end
            mag = mag / VALUE_W'(base);
        end while (mag != '0);
        if (neg) begin
            queue_char(ASCII_MINUS);
        end
        for (i = n; i > nfrac; i--) begin
            queue_char(digit_glyph(digits[i-1]));
        end
        if (nfrac > 0) begin
            queue_char(ASCII_POINT);
            for (i = nfrac; i > 0; i--) begin
                queue_char(digit_glyph(digits[i-1]));
            end
        end
        // Mark the final character
        tail = text_queue.pop_back();
        tail.last = 1'b1;
        text_queue = {text_queue, tail};
    endfunction

    function automatic void flag_mismatch(input string msg);
        if (mismatches < REPORT_CAP) begin
            $display("%0t ns: mismatch: %s", $realtime, msg);
        end
        mismatches++;
    endfunction

    always @(posedge i_clk) begin
        t_char_beat want;
        if (!i_rst_n) begin
            radix_q = RADIX_RESET;
            frac_q  = '0;
            text_queue.delete();
        end else begin
            // Track register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_RADIX) begin
                    radix_q = i_pwdata[RADIX_W-1:0];
                end else begin
                    frac_q = i_pwdata[FRAC_W-1:0];
                end
            end
            // Predict on every accepted input beat
            if (i_in_valid && !i_in_stall) begin
                predict_text(i_scaled_value);
            end
            // Compare every accepted output beat with the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (text_queue.size() == 0) begin
                    flag_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                            i_text_char, i_last_char));
                end else begin
                    want = text_queue.pop_front();
                    if (i_text_char !== want.ch || i_last_char !== want.last) begin
                        flag_mismatch($sformatf(
                            "char expected 0x%02h last %0b, got 0x%02h last %0b",
                            want.ch, want.last, i_text_char, i_last_char));
                    end
                end
            end
        end
        o_pending = text_queue.size();
    end

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rfpa_pkg::*;

    localparam int VALUE_W     = 32;
    localparam int STALL_LIMIT = 3000;
    localparam int RANDOM_ITEMS = 138;

    localparam logic [2:0] ADDR_RADIX = {REG_RADIX, 2'b00};
    localparam logic [2:0] ADDR_FRAC  = {REG_FRAC, 2'b00};

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_ALTERNATE,
        STALL_HOLD
    } t_stall_mode;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [2:0]                paddr;
    logic [31:0]               pwdata;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic signed [VALUE_W-1:0] i_scaled_value;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [CHAR_W-1:0]         o_text_char;
    logic                      o_last_char;

    int mismatch_count;
    int pending_chars;
    int burst_left = 0;
    int idle_cycles = 0;

    radix_fixed_point_to_ascii dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_scaled_value(i_scaled_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_text_char   (o_text_char),
        .o_last_char   (o_last_char)
    );

    rfpa_text_checker #(.VALUE_W(VALUE_W)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_scaled_value(i_scaled_value),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_text_char   (o_text_char),
        .i_last_char   (o_last_char),
        .o_mismatches  (mismatch_count),
        .o_pending     (pending_chars)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Offer one number, in bursts with random gaps, and hold it until taken
    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_scaled_value <= v;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and wait until every expected character has come out
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_chars != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [4:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {27'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_format(input logic [4:0] base, input logic [4:0] nfrac);
        drain();
        apb_write(ADDR_RADIX, base);
        apb_write(ADDR_FRAC, nfrac);
    endtask

    // Receiver stall pattern: segments of random mode and length
    initial begin
        t_stall_mode mode;
        int          span;
        int          k;
        i_out_stall = 1'b0;
        forever begin
            mode = t_stall_mode'($urandom_range(0, 4));
            span = (mode == STALL_HOLD) ? $urandom_range(2, 20) : $urandom_range(8, 48);
            for (k = 0; k < span; k++) begin
                @(negedge i_clk);
                case (mode)
                    STALL_NONE:      i_out_stall <= 1'b0;
                    STALL_LIGHT:     i_out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:     i_out_stall <= ($urandom_range(0, 3) != 0);
                    STALL_ALTERNATE: i_out_stall <= k[0];
                    default:         i_out_stall <= 1'b1;
                endcase
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable && pwrite && pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int                        remaining;
        int                        phase_len;
        logic [4:0]                base;
        logic [4:0]                nfrac;
        logic signed [VALUE_W-1:0] v;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_in_valid     = 1'b0;
        i_scaled_value = '0;
        i_rst_n        = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset format: base ten, no fraction
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd1234);
        send_value(-32'sd123456);

        // Binary with the widest fraction
        set_format(5'd2, 5'd31);
        send_value(32'h8000_0000);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);

        // Hex, no fraction, then the widest fraction
        set_format(5'd16, 5'd0);
        send_value(32'h7FFF_FFFF);
        send_value(32'h89AB_CDEF);
        send_value(32'd0);
        set_format(5'd16, 5'd31);
        send_value(32'h1234_5678);
        send_value(-32'sd5);

        // Radix below two and above sixteen saturate
        set_format(5'd0, 5'd3);
        send_value(32'd13);
        send_value(-32'sd8);
        set_format(5'd31, 5'd1);
        send_value(32'd255);
        send_value(-32'sd256);

        // Odd base, zero with leading fraction zeros
        set_format(5'd3, 5'd7);
        send_value(32'd0);
        send_value(32'h5555_5555);

        // Random formats, each held for a phase of random numbers
        remaining = RANDOM_ITEMS;
        while (remaining > 0) begin
            base = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(2, 16));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: nfrac = 5'($urandom_range(0, 4));
                5, 6, 7:       nfrac = 5'($urandom_range(5, 12));
                default:       nfrac = 5'($urandom_range(13, 31));
            endcase
            set_format(base, nfrac);
            phase_len = $urandom_range(12, 28);
            if (phase_len > remaining) begin
                phase_len = remaining;
            end
            repeat (phase_len) begin
                case ($urandom_range(0, 3))
                    0: v = VALUE_W'($urandom);
                    1: v = VALUE_W'(int'($urandom_range(0, 2000)) - 1000);
                    2: v = $signed(VALUE_W'($urandom)) >>> $urandom_range(0, 31);
                    default: v = ($urandom_range(0, 1) == 1)
                                 ? (32'h7FFF_FFFF - VALUE_W'($urandom_range(0, 3)))
                                 : (32'h8000_0000 + VALUE_W'($urandom_range(0, 3)));
                endcase
                send_value(v);
            end
            remaining -= phase_len;
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rfpa_pkg.sv
rtl/core/rfpa_ram.sv
rtl/core/rfpa_ctrl.sv
rtl/core/rfpa_dp.sv
rtl/core/radix_fixed_point_to_ascii.sv
tb/rfpa_text_checker.sv
tb/tb.sv
